### hdl/rpy_pkg.sv
// Types, constants and fixed-point helpers for the RPY diffusion tensor block.
// Used by rpy_diffusion_tensor_block; no other dependencies.
`default_nettype none
package rpy_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAGW      = 32;
	localparam int SQ_N      = 32;               // root bits, one per sqrt stage
	localparam int DV_N      = MAGW;             // quotient bits, one per divide stage
	localparam int NW        = MAGW + FRAC_BITS + 1;
	localparam int LAT       = 2 + SQ_N + 2 + DV_N + 7;

	localparam logic [MAGW-1:0] MAGMAX = '1;
	localparam logic [MAGW-1:0] ONEQ   = MAGW'(1) << FRAC_BITS;
	localparam logic [MAGW-1:0] HALFQ  = MAGW'(1) << (FRAC_BITS - 1);
	localparam logic [MAGW-1:0] C9     = MAGW'(9) << (FRAC_BITS - 5);
	localparam logic [MAGW-1:0] C3     = MAGW'(3) << (FRAC_BITS - 5);
	localparam logic [MAGW-1:0] C34    = MAGW'(3) << (FRAC_BITS - 2);
	localparam logic [MAGW-1:0] RECIP3 = 32'hAAAA_AAAB;   // ceil(2^33 / 3)

	typedef enum logic [1:0] {
		CFG_KT  = 2'd0,
		CFG_RAD = 2'd1,
		CFG_OVR = 2'd2
	} cfg_idx_t;

	// sign and magnitude; neg is never set with a zero magnitude
	typedef struct packed {
		logic            neg;
		logic [MAGW-1:0] m;
	} sm_t;

	typedef struct packed {
		logic                 self;
		logic [2:0]           neg;
		logic [2:0][MAGW-1:0] mag;
	} side_t;

	typedef struct packed {
		logic [35:0] rem;
		logic [31:0] root;
		logic [63:0] x;
	} sqst_t;

	typedef struct packed {
		logic [MAGW-1:0] ua;
		logic [MAGW-1:0] ub;
		logic            neg;
	} dvin_t;

	typedef struct packed {
		logic [MAGW-1:0] rem;
		logic [MAGW-1:0] low;
		logic [MAGW-1:0] q;
		logic [MAGW-1:0] ub;
		logic            neg;
		logic            ovf;
		logic            nil;
	} dvst_t;

	typedef struct packed {
		logic self;
		logic ovl;
	} ctl_t;

	// product with round half away from zero, saturated magnitude
	function automatic sm_t mulq(sm_t a, sm_t b);
		logic [63:0]          pr;
		logic [64:0]          p;
		logic [64-FRAC_BITS:0] r;
		sm_t                  o;
		pr    = 64'(a.m) * 64'(b.m);
		p     = {1'b0, pr} + 65'(HALFQ);
		r     = p[64:FRAC_BITS];
		o.m   = (|r[64-FRAC_BITS:MAGW]) ? MAGMAX : r[MAGW-1:0];
		o.neg = (a.neg ^ b.neg) && (o.m != '0);
		return o;
	endfunction

	function automatic logic signed [34:0] sm2s(sm_t a);
		logic signed [34:0] v;
		v = $signed({3'b000, a.m});
		return a.neg ? -v : v;
	endfunction

	function automatic sm_t s2sm(logic signed [34:0] v);
		logic [34:0] mv;
		sm_t         o;
		mv    = v[34] ? 35'(-v) : 35'(v);
		o.m   = (|mv[34:MAGW]) ? MAGMAX : mv[MAGW-1:0];
		o.neg = v[34] && (o.m != '0);
		return o;
	endfunction

	// clamp to the int32 range
	function automatic logic [31:0] out32(sm_t a);
		if (a.neg)
			return a.m[31] ? 32'h8000_0000 : 32'(-a.m);
		return a.m[31] ? 32'h7FFF_FFFF : a.m;
	endfunction

	// one digit of the exact integer square root
	function automatic sqst_t sqrt_step(sqst_t s);
		logic [35:0] remsh;
		logic [35:0] trial;
		sqst_t       o;
		remsh = {s.rem[33:0], s.x[63:62]};
		trial = {2'b00, s.root, 2'b01};
		if (remsh >= trial) begin
			o.rem  = remsh - trial;
			o.root = {s.root[30:0], 1'b1};
		end else begin
			o.rem  = remsh;
			o.root = {s.root[30:0], 1'b0};
		end
		o.x = {s.x[61:0], 2'b00};
		return o;
	endfunction

	// one quotient bit of the restoring divider
	function automatic dvst_t div_step(dvst_t s);
		logic [MAGW:0] remsh;
		dvst_t         o;
		o     = s;
		remsh = {s.rem, s.low[MAGW-1]};
		if (remsh >= {1'b0, s.ub}) begin
			o.rem = MAGW'(remsh - {1'b0, s.ub});
			o.q   = {s.q[MAGW-2:0], 1'b1};
		end else begin
			o.rem = remsh[MAGW-1:0];
			o.q   = {s.q[MAGW-2:0], 1'b0};
		end
		o.low = {s.low[MAGW-2:0], 1'b0};
		return o;
	endfunction

	function automatic dvst_t div_init(dvin_t d);
		logic [NW-1:0] n;
		dvst_t         o;
		n     = {1'b0, d.ua, FRAC_BITS'(0)} + NW'(d.ub >> 1);
		o.rem = MAGW'(n[NW-1:MAGW]);
		o.low = n[MAGW-1:0];
		o.q   = '0;
		o.ub  = d.ub;
		o.neg = d.neg;
		o.nil = (d.ub == '0) && (d.ua == '0);
		o.ovf = (d.ub == '0) ? (d.ua != '0) : (64'(n) >= {d.ub, 32'd0});
		return o;
	endfunction

	function automatic sm_t div_res(dvst_t s);
		sm_t o;
		o.m   = s.nil ? '0 : (s.ovf ? MAGMAX : s.q);
		o.neg = s.neg && (o.m != '0);
		return o;
	endfunction

endpackage
`default_nettype wire

### hdl/rpy_diffusion_tensor_block.sv
// Top level of the RPY diffusion tensor block: one bead pair in, six tensor entries out.
// Depends on rpy_pkg for types, constants and fixed-point helpers.
`default_nettype none
// Fully pipelined: one bead pair is accepted every cycle and results appear in order,
// but a stall on the output freezes the whole pipeline; nothing is dropped or repeated.
// It is built from the 32-stage square-root pipeline (one root bit per stage) and the
// 32-stage divider pipeline (one quotient bit per stage, four dividers in parallel),
// plus the multiplier stages around them. Self pairs return kT/zeta on xx and yy, zero
// elsewhere and overlap_used low. The user writes configuration through
// cfg_we/cfg_addr/cfg_wdata only while the block is idle; not enforced by the block.
module rpy_diffusion_tensor_block (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [30:0]  cfg_wdata,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [95:0]  s_axis_tdata,   // delta_x, delta_y, delta_z
	input  wire logic [0:0]   s_axis_tuser,   // self_pair
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [191:0]      m_axis_tdata,   // entry_xx, xy, xz, yy, yz, zz
	output logic [0:0]        m_axis_tuser    // overlap_used
);

	logic [30:0] kt_q, rad_q, ovr_q;
	logic [rpy_pkg::LAT-1:0] vld_q;
	logic en;

	rpy_pkg::side_t   side_s1, side_s2;
	logic [2:0][63:0] sq_s1;
	logic [63:0]      r2_s2;
	rpy_pkg::sqst_t   rt_s3 [rpy_pkg::SQ_N];
	rpy_pkg::side_t   rside_s3 [rpy_pkg::SQ_N];
	rpy_pkg::dvin_t   dvin_s4 [4];
	rpy_pkg::ctl_t    ctl_s4, ctl_s5;
	rpy_pkg::dvst_t   dv_s5 [4];
	rpy_pkg::dvst_t   dv_s6 [rpy_pkg::DV_N][4];
	rpy_pkg::ctl_t    dctl_s6 [rpy_pkg::DV_N];
	rpy_pkg::ctl_t    ctl_s7, ctl_s8, ctl_s9, ctl_s10, ctl_s11, ctl_s12;
	rpy_pkg::sm_t     a1_s7, b1_s7, a2_s8, b2_s8, a3_s9, b3_s9, sb_s9;
	rpy_pkg::sm_t     al_s10, be_s10, al_s11;
	rpy_pkg::sm_t     nn_s7 [6], nn_s8 [6], nn_s9 [6], nn_s10 [6], t_s11 [6], e_s12 [6];
	logic [31:0]      od_s13 [6];
	logic             ou_s13;

	rpy_pkg::sqst_t   sq_init;
	rpy_pkg::sm_t     qv, nv [3], kt_sm;
	logic [31:0]      dlt [3];
	logic [31:0]      d_root;
	logic             ovl_c;

	// pipeline advances unless the output beat is held
	assign en            = ~vld_q[rpy_pkg::LAT-1] | m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[rpy_pkg::LAT-1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kt_q  <= 31'd65536;
			rad_q <= 31'd235930;
			ovr_q <= 31'd235930;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				rpy_pkg::CFG_KT:  kt_q  <= cfg_wdata;
				rpy_pkg::CFG_RAD: rad_q <= cfg_wdata;
				rpy_pkg::CFG_OVR: ovr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[rpy_pkg::LAT-2:0], s_axis_tvalid};
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++)
			dlt[k] = s_axis_tdata[32*k +: 32];
		sq_init.rem  = '0;
		sq_init.root = '0;
		sq_init.x    = r2_s2;
		d_root = rt_s3[rpy_pkg::SQ_N-1].root;
		ovl_c  = (d_root == '0) || ({1'b0, d_root} < {1'b0, ovr_q, 1'b0});
		qv     = rpy_pkg::div_res(dv_s6[rpy_pkg::DV_N-1][0]);
		for (int k = 0; k < 3; k++)
			nv[k] = rpy_pkg::div_res(dv_s6[rpy_pkg::DV_N-1][k+1]);
		kt_sm = {1'b0, 1'b0, kt_q};
	end

	// squares, sum, square root
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.self <= s_axis_tuser[0];
			for (int k = 0; k < 3; k++) begin
				side_s1.neg[k] <= dlt[k][31];
				side_s1.mag[k] <= dlt[k][31] ? 32'(-dlt[k]) : dlt[k];
				sq_s1[k] <= (dlt[k][31] ? 64'(32'(-dlt[k])) : 64'(dlt[k]))
				          * (dlt[k][31] ? 64'(32'(-dlt[k])) : 64'(dlt[k]));
			end
			side_s2 <= side_s1;
			r2_s2   <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			for (int k = 0; k < rpy_pkg::SQ_N; k++) begin
				if (k == 0) begin
					rt_s3[k]    <= rpy_pkg::sqrt_step(sq_init);
					rside_s3[k] <= side_s2;
				end else begin
					rt_s3[k]    <= rpy_pkg::sqrt_step(rt_s3[k-1]);
					rside_s3[k] <= rside_s3[k-1];
				end
			end
		end
	end

	// form selection and divider setup
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4.self    <= rside_s3[rpy_pkg::SQ_N-1].self;
			ctl_s4.ovl     <= ovl_c;
			dvin_s4[0].ua  <= ovl_c ? d_root : {1'b0, rad_q};
			dvin_s4[0].ub  <= ovl_c ? {1'b0, rad_q} : d_root;
			dvin_s4[0].neg <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				dvin_s4[k+1].ua  <= rside_s3[rpy_pkg::SQ_N-1].mag[k];
				dvin_s4[k+1].ub  <= d_root;
				dvin_s4[k+1].neg <= rside_s3[rpy_pkg::SQ_N-1].neg[k];
			end
			ctl_s5 <= ctl_s4;
			for (int j = 0; j < 4; j++)
				dv_s5[j] <= rpy_pkg::div_init(dvin_s4[j]);
		end
	end

	// divider pipeline: q = d/a or u = a/d, and the unit direction
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < rpy_pkg::DV_N; k++) begin
				for (int j = 0; j < 4; j++) begin
					if (k == 0)
						dv_s6[k][j] <= rpy_pkg::div_step(dv_s5[j]);
					else
						dv_s6[k][j] <= rpy_pkg::div_step(dv_s6[k-1][j]);
				end
				if (k == 0)
					dctl_s6[k] <= ctl_s5;
				else
					dctl_s6[k] <= dctl_s6[k-1];
			end
		end
	end

	// alpha, beta and direction products
	always_ff @(posedge clk) begin
		if (en) begin
			// first products
			ctl_s7 <= dctl_s6[rpy_pkg::DV_N-1];
			a1_s7  <= dctl_s6[rpy_pkg::DV_N-1].ovl ?
			          rpy_pkg::mulq({1'b0, rpy_pkg::C9}, qv) : rpy_pkg::mulq(qv, qv);
			b1_s7  <= dctl_s6[rpy_pkg::DV_N-1].ovl ?
			          rpy_pkg::mulq({1'b0, rpy_pkg::C3}, qv) :
			          rpy_pkg::mulq({1'b0, rpy_pkg::C34}, qv);
			nn_s7[0] <= rpy_pkg::mulq(nv[0], nv[0]);
			nn_s7[1] <= rpy_pkg::mulq(nv[0], nv[1]);
			nn_s7[2] <= rpy_pkg::mulq(nv[0], nv[2]);
			nn_s7[3] <= rpy_pkg::mulq(nv[1], nv[1]);
			nn_s7[4] <= rpy_pkg::mulq(nv[1], nv[2]);
			nn_s7[5] <= rpy_pkg::mulq(nv[2], nv[2]);

			// overlap alpha, or far-field t2 = 2 u^2
			ctl_s8 <= ctl_s7;
			b2_s8  <= b1_s7;
			nn_s8  <= nn_s7;
			if (ctl_s7.ovl)
				a2_s8 <= rpy_pkg::s2sm(35'(signed'({3'b000, rpy_pkg::ONEQ}))
				                       - rpy_pkg::sm2s(a1_s7));
			else
				a2_s8 <= {1'b0, a1_s7.m[31] ? rpy_pkg::MAGMAX : {a1_s7.m[30:0], 1'b0}};

			// t2 / 3 rounded to nearest (overlap alpha passes through), and 1 - t2
			ctl_s9 <= ctl_s8;
			b3_s9  <= b2_s8;
			nn_s9  <= nn_s8;
			sb_s9  <= rpy_pkg::s2sm(35'(signed'({3'b000, rpy_pkg::ONEQ}))
			                        - rpy_pkg::sm2s(a2_s8));
			if (ctl_s8.ovl)
				a3_s9 <= a2_s8;
			else
				a3_s9 <= {1'b0, 32'(((66'(a2_s8.m) + 66'd1) * 66'(rpy_pkg::RECIP3)) >> 33)};

			// final alpha and beta
			ctl_s10 <= ctl_s9;
			nn_s10  <= nn_s9;
			if (ctl_s9.ovl) begin
				al_s10 <= a3_s9;
				be_s10 <= b3_s9;
			end else begin
				al_s10 <= rpy_pkg::mulq(b3_s9, rpy_pkg::s2sm(
				          35'(signed'({3'b000, rpy_pkg::ONEQ})) + rpy_pkg::sm2s(a3_s9)));
				be_s10 <= rpy_pkg::mulq(b3_s9, sb_s9);
			end

			// beta times direction terms
			ctl_s11 <= ctl_s10;
			al_s11  <= al_s10;
			for (int j = 0; j < 6; j++)
				t_s11[j] <= rpy_pkg::mulq(be_s10, nn_s10[j]);

			// add alpha on the diagonal
			ctl_s12 <= ctl_s11;
			for (int j = 0; j < 6; j++) begin
				if (j == 0 || j == 3 || j == 5)
					e_s12[j] <= rpy_pkg::s2sm(rpy_pkg::sm2s(al_s11)
					                          + rpy_pkg::sm2s(t_s11[j]));
				else
					e_s12[j] <= t_s11[j];
			end

			// scale by kT/zeta, clamp; self pair override
			ou_s13 <= ~ctl_s12.self & ctl_s12.ovl;
			for (int j = 0; j < 6; j++) begin
				if (ctl_s12.self)
					od_s13[j] <= (j == 0 || j == 3) ? {1'b0, kt_q} : 32'd0;
				else
					od_s13[j] <= rpy_pkg::out32(rpy_pkg::mulq(kt_sm, e_s12[j]));
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 6; j++)
			m_axis_tdata[32*j +: 32] = od_s13[j];
		m_axis_tuser[0] = ou_s13;
	end

endmodule
`default_nettype wire
